### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the prefix match RTL; empty bodies
// when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define LPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define LPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define LPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define LPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/lpm_pkg.sv
// ---------------------------------------------------------------------------
// Prefix match package
// Sizes, opcodes and record types shared by the trie prefix match modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpm_pkg;

    // Trie node pool size; the root is node 0.
    localparam int NODES       = 1024;
    localparam int NODE_W      = $clog2(NODES);
    localparam int CNT_W       = $clog2(NODES + 1);

    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 6;
    localparam int TAG_W       = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_LOOKUP = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef enum logic [0:0] {
        STAT_OK        = 1'b0,
        STAT_POOL_FULL = 1'b1
    } status_t;

    // Command handed from the front end to the walker.
    typedef struct packed {
        op_t                op;
        logic [ADDR_W-1:0]  addr;
        logic [LEN_W-1:0]   plen;
        logic [TAG_W-1:0]   tag;
    } cmd_t;

    // One trie node: child links (0 means no child), entry flag and tag.
    typedef struct packed {
        logic [NODE_W-1:0]  left;
        logic [NODE_W-1:0]  right;
        logic               valid;
        logic [TAG_W-1:0]   tag;
    } node_t;

    typedef struct packed {
        logic               hit;
        logic [TAG_W-1:0]   match_tag;
        logic               exact;
        status_t            status;
    } result_t;

endpackage

### rtl/lpm_if.sv
// ---------------------------------------------------------------------------
// Prefix match channels
// Valid/ready channels for request items and result items.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpm_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [lpm_pkg::ADDR_W-1:0]  key_address;
    logic [lpm_pkg::LEN_W-1:0]   prefix_length;
    logic [lpm_pkg::TAG_W-1:0]   info_tag;

    modport source (output valid, output opcode, output key_address,
                    output prefix_length, output info_tag, input ready);
    modport sink   (input valid, input opcode, input key_address,
                    input prefix_length, input info_tag, output ready);
endinterface

interface lpm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [lpm_pkg::TAG_W-1:0]   match_tag;
    logic                        exact;
    logic                        status;

    modport source (output valid, output hit, output match_tag, output exact,
                    output status, input ready);
    modport sink   (input valid, input hit, input match_tag, input exact,
                    input status, output ready);
endinterface

### rtl/lpm_front.sv
// ---------------------------------------------------------------------------
// Prefix match front end
// Accepts request items, decodes the opcode, clamps the prefix length and
// registers the resulting command for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpm_front (
    input  logic            clk,
    input  logic            rst_n,
    lpm_req_if.sink         req,
    output logic            cmd_valid,
    input  logic            cmd_ready,
    output lpm_pkg::cmd_t   cmd
);
    import lpm_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    logic  take;

    assign req.ready = !valid_reg || cmd_ready;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        cmd_next      = cmd_reg;
        cmd_next.op   = op_t'(req.opcode);
        cmd_next.addr = req.key_address;
        cmd_next.tag  = req.info_tag;
        // Prefix lengths beyond the address width mean a full host route.
        if (req.prefix_length > LEN_W'(ADDR_W))
        begin
            cmd_next.plen = LEN_W'(ADDR_W);
        end
        else
        begin
            cmd_next.plen = req.prefix_length;
        end

        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

### rtl/lpm_queue.sv
// ---------------------------------------------------------------------------
// Prefix match command queue
// Short FIFO that lets the front end and the trie walker stall independently.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lpm_pkg::cmd_t   push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output lpm_pkg::cmd_t   pop_data
);
    import lpm_pkg::*;

    cmd_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    `LPM_ASSERT(a_queue_count, clk, rst_n, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
    `LPM_ASSERT_IMP(a_queue_empty_ptrs, clk, rst_n, count_reg == '0, wr_ptr_reg == rd_ptr_reg, "empty queue with split pointers")

endmodule

### rtl/lpm_walker.sv
// ---------------------------------------------------------------------------
// Prefix match trie walker
// Walks the binary trie one level per cycle for lookups and inserts, owns the
// node memories and holds the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpm_walker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  lpm_pkg::cmd_t      cmd,
    output logic               res_valid,
    input  logic               res_ready,
    output lpm_pkg::result_t   res
);
    import lpm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Node memories; entry 0 of the link memory is shadowed by root registers.
    node_t              links_mem [NODES];
    logic [ADDR_W-1:0]  addr_mem  [NODES];
    node_t              links_q;
    logic [ADDR_W-1:0]  addr_q;

    state_t             state_reg;
    state_t             state_next;
    node_t              root_reg;
    node_t              root_next;
    logic [CNT_W-1:0]   nodes_used_reg;
    logic [CNT_W-1:0]   nodes_used_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            out_reg;
    result_t            out_next;

    op_t                op_reg;
    op_t                op_next;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [ADDR_W-1:0]  shift_reg;
    logic [ADDR_W-1:0]  shift_next;
    logic [LEN_W-1:0]   plen_reg;
    logic [LEN_W-1:0]   plen_next;
    logic [TAG_W-1:0]   tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic [NODE_W-1:0]  node_reg;
    logic [NODE_W-1:0]  node_next;
    logic [LEN_W-1:0]   depth_reg;
    logic [LEN_W-1:0]   depth_next;
    logic               fresh_reg;
    logic               fresh_next;
    logic               found_reg;
    logic               found_next;
    logic [TAG_W-1:0]   best_reg;
    logic [TAG_W-1:0]   best_next;
    result_t            done_reg;
    result_t            done_next;

    node_t              cur;
    node_t              wr_node;
    logic               links_we;
    logic               addr_we;
    logic [NODE_W-1:0]  rd_addr;
    logic               step_bit;
    logic [NODE_W-1:0]  child;
    logic               hit_now;
    logic [TAG_W-1:0]   best_now;

    always_comb
    begin
        // A node allocated by this insert has not been written yet: it is empty.
        if (fresh_reg)
        begin
            cur = '0;
        end
        else if (node_reg == '0)
        begin
            cur = root_reg;
        end
        else
        begin
            cur = links_q;
        end
        step_bit = shift_reg[ADDR_W-1];
        child    = step_bit ? cur.right : cur.left;
        hit_now  = found_reg || cur.valid;
        best_now = cur.valid ? cur.tag : best_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        root_next       = root_reg;
        nodes_used_next = nodes_used_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        shift_next      = shift_reg;
        plen_next       = plen_reg;
        tag_next        = tag_reg;
        node_next       = node_reg;
        depth_next      = depth_reg;
        fresh_next      = fresh_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        done_next       = done_reg;
        wr_node         = cur;
        links_we        = 1'b0;
        addr_we         = 1'b0;
        rd_addr         = node_reg;
        cmd_ready       = 1'b0;

        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                rd_addr   = '0;
                if (cmd_valid)
                begin
                    op_next    = cmd.op;
                    addr_next  = cmd.addr;
                    shift_next = cmd.addr;
                    plen_next  = cmd.plen;
                    tag_next   = cmd.tag;
                    node_next  = '0;
                    depth_next = '0;
                    fresh_next = 1'b0;
                    found_next = 1'b0;
                    best_next  = '0;
                    state_next = ST_WALK;
                end
            end

            ST_WALK:
            begin
                done_next = '0;
                unique case (op_reg)
                    OP_LOOKUP:
                    begin
                        found_next = hit_now;
                        best_next  = best_now;
                        if (depth_reg == LEN_W'(ADDR_W) || child == '0)
                        begin
                            done_next.hit       = hit_now;
                            done_next.match_tag = hit_now ? best_now : '0;
                            done_next.exact     = cur.valid && (addr_q == addr_reg);
                            done_next.status    = STAT_OK;
                            state_next          = ST_DONE;
                        end
                        else
                        begin
                            node_next  = child;
                            rd_addr    = child;
                            depth_next = depth_reg + 1'b1;
                            shift_next = shift_reg << 1;
                        end
                    end

                    OP_INSERT:
                    begin
                        if (depth_reg == plen_reg)
                        begin
                            wr_node.valid = 1'b1;
                            wr_node.tag   = tag_reg;
                            links_we      = 1'b1;
                            addr_we       = 1'b1;
                            state_next    = ST_DONE;
                        end
                        else if (child != '0)
                        begin
                            node_next  = child;
                            rd_addr    = child;
                            fresh_next = 1'b0;
                            depth_next = depth_reg + 1'b1;
                            shift_next = shift_reg << 1;
                        end
                        else if (nodes_used_reg >= CNT_W'(NODES))
                        begin
                            // Pool exhausted: leave an allocated node empty.
                            wr_node          = '0;
                            links_we         = fresh_reg;
                            done_next.status = STAT_POOL_FULL;
                            state_next       = ST_DONE;
                        end
                        else
                        begin
                            if (step_bit)
                            begin
                                wr_node.right = nodes_used_reg[NODE_W-1:0];
                            end
                            else
                            begin
                                wr_node.left = nodes_used_reg[NODE_W-1:0];
                            end
                            links_we        = 1'b1;
                            nodes_used_next = nodes_used_reg + 1'b1;
                            node_next       = nodes_used_reg[NODE_W-1:0];
                            rd_addr         = nodes_used_reg[NODE_W-1:0];
                            fresh_next      = 1'b1;
                            depth_next      = depth_reg + 1'b1;
                            shift_next      = shift_reg << 1;
                        end
                    end

                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = done_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (links_we && node_reg == '0)
        begin
            root_next = wr_node;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            root_reg       <= '0;
            nodes_used_reg <= CNT_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            root_reg       <= root_next;
            nodes_used_reg <= nodes_used_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        op_reg    <= op_next;
        addr_reg  <= addr_next;
        shift_reg <= shift_next;
        plen_reg  <= plen_next;
        tag_reg   <= tag_next;
        node_reg  <= node_next;
        depth_reg <= depth_next;
        fresh_reg <= fresh_next;
        found_reg <= found_next;
        best_reg  <= best_next;
        done_reg  <= done_next;
    end

    always_ff @(posedge clk)
    begin
        if (links_we)
        begin
            links_mem[node_reg] <= wr_node;
        end
        links_q <= links_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (addr_we)
        begin
            addr_mem[node_reg] <= addr_reg;
        end
        addr_q <= addr_mem[rd_addr];
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    `LPM_ASSERT_IMP(a_walk_depth, clk, rst_n, state_reg == ST_WALK, depth_reg <= LEN_W'(ADDR_W), "walk went past the last address bit")
    `LPM_ASSERT_IMP(a_walk_node_alloc, clk, rst_n, state_reg == ST_WALK, CNT_W'(node_reg) < nodes_used_reg, "walk reached an unallocated node")
    `LPM_ASSERT_NXT(a_pool_stable, clk, rst_n, state_reg != ST_WALK, nodes_used_reg == $past(nodes_used_reg), "node pool changed outside a walk")

endmodule

### rtl/trie_longest_prefix_match.sv
// ---------------------------------------------------------------------------
// Binary trie longest prefix match
// A request item passes through the front-end register and the command
// queue to the walker, which visits one trie level per cycle and then loads
// the result register once the output is free. The walker takes one item at
// a time, while the front end and queue go on taking new items. Reset is
// asynchronous and active low, empties the trie to a lone root and takes
// effect immediately.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// The design splits into a front end that accepts each item, decodes the
// opcode and clamps the prefix length, a two-entry command queue, and a
// walker that owns the trie. The walker reads one node per cycle from a
// synchronous node memory: the read for the next level is issued in the same
// cycle that the current node is evaluated, so the walk advances a level
// every cycle. The root lives in flip-flops, so reset clears the trie at once
// and no clearing pass is needed; other nodes are only reachable through a
// link written when they were allocated.
//
// An insert writes only the nodes it changes, each as it leaves it, so the
// memory keeps a single write port: a node allocated on the way down is
// treated as empty until that write happens. If the pool runs out mid-walk
// the fresh node is written back empty and the result reports a full pool.
//
// The walker keeps its own result register, so a finished result can wait on
// the output while the front end and queue go on taking new items.

module trie_longest_prefix_match (
    input  logic    clk,
    input  logic    rst_n,
    lpm_req_if.sink req,
    lpm_rsp_if.source rsp
);
    import lpm_pkg::*;

    logic     front_valid;
    logic     front_ready;
    cmd_t     front_cmd;
    logic     queue_valid;
    logic     queue_ready;
    cmd_t     queue_cmd;
    logic     res_valid;
    result_t  res;

    lpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    lpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    lpm_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .res_valid (res_valid),
        .res_ready (rsp.ready),
        .res       (res)
    );

    // The result channel is driven straight from the walker's output register.
    assign rsp.valid     = res_valid;
    assign rsp.hit       = res.hit;
    assign rsp.match_tag = res.match_tag;
    assign rsp.exact     = res.exact;
    assign rsp.status    = res.status;

endmodule
